FILE: hdl/idw_pkg.sv
// Shared types, constants and a helper function for the idle timeout wheel.
// Has no dependencies; every other file of the block but idw_ram uses it.
`default_nettype none

package idw_pkg;

  localparam int MAX_CONN    = 64;
  localparam int WHEEL_SLOTS = 16;

  localparam int ID_W    = 6;
  localparam int TICKS_W = 5;
  localparam int CNT_W   = 5;
  localparam int CONN_W  = (MAX_CONN > 1) ? $clog2(MAX_CONN) : 1;
  localparam int SLOT_W  = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;
  localparam int NUM_W   = SLOT_W + 1;

  localparam logic [TICKS_W-1:0] IDLE_TICKS_RST = TICKS_W'(8);
  localparam logic [CONN_W-1:0]  LAST_CONN      = CONN_W'(MAX_CONN - 1);

  localparam logic OP_ACTIVITY = 1'b0;
  localparam logic OP_TICK     = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACT,
    S_SCAN,
    S_UPD,
    S_PUSH,
    S_END
  } state_t;

  typedef struct packed {
    logic              set_en;
    logic              clr_en;
    logic              clr_all;
    logic [SLOT_W-1:0] wr_slot;
    logic [CONN_W-1:0] id;
    logic [SLOT_W-1:0] rd_slot;
  } bkt_cmd_t;

  // Effective ring length: zero acts as one, large values clamp to the ring size.
  function automatic logic [NUM_W-1:0] slots_in_use(input logic [TICKS_W-1:0] ticks);
    logic [31:0] t;
    t = 32'(ticks);
    if (t == 32'd0) begin
      t = 32'd1;
    end
    if (t > 32'(WHEEL_SLOTS)) begin
      t = 32'(WHEEL_SLOTS);
    end
    return t[NUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/idw_in_if.sv
// Input channel of the idle timeout wheel: activity and tick beats.
// Depends on idw_pkg for the field widths.
`default_nettype none

interface idw_in_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [idw_pkg::ID_W-1:0]  conn_id;

  modport source (output valid, output opcode, output conn_id, input ready);
  modport sink   (input valid, input opcode, input conn_id, output ready);
endinterface

`default_nettype wire

FILE: hdl/idw_out_if.sv
// Output channel of the idle timeout wheel: one beat per expired connection.
// Depends on idw_pkg for the field widths.
`default_nettype none

interface idw_out_if;
  logic                      valid;
  logic                      ready;
  logic [idw_pkg::ID_W-1:0]  expired_conn;
  logic                      last;

  modport source (output valid, output expired_conn, output last, input ready);
  modport sink   (input valid, input expired_conn, input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/idle_timeout_wheel_top.sv
// Top level of the idle timeout wheel: configuration register, bucket store,
// reference count RAM and sequencer. Depends on idw_pkg, the channel
// interfaces, idw_ram, idw_buckets and idw_ctrl.
`default_nettype none

// Sequencing:
//   An activity beat reads the reference count from the RAM in the accept
//   cycle and writes it back, with the bucket bit, in the next.
//   A tick beat walks all connections one after another with the one count
//   unit and the single RAM, visits each member of the retiring bucket in an
//   update step and each expiry after the first in a push step; the output
//   side can stall the walk. No new beat is accepted until the tick is done.
// Reset: synchronous; all buckets, count valid bits and the ring pointer clear
//   together, idle_ticks returns to 8. No clearing pass is needed.
module idle_timeout_wheel_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  idw_in_if.sink                             evt,
  idw_out_if.source                          expiry,
  input  wire logic                          cfg_we,
  input  wire logic [idw_pkg::TICKS_W-1:0]   cfg_data
);

  // The configured slot count. A write also clears the whole wheel, which the
  // sequencer and the bucket store see through cfg_we in the same cycle.
  logic [idw_pkg::TICKS_W-1:0] idle_ticks;
  logic [idw_pkg::NUM_W-1:0]   num_slots;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_ticks <= idw_pkg::IDLE_TICKS_RST;
    end else if (cfg_we) begin
      idle_ticks <= cfg_data;
    end
  end

  // Zero acts as one slot, values above the ring size act as the ring size.
  assign num_slots = idw_pkg::slots_in_use(idle_ticks);

  idw_pkg::bkt_cmd_t              bcmd;
  logic [idw_pkg::MAX_CONN-1:0]   bkt_word;
  logic                           ram_we;
  logic [idw_pkg::CONN_W-1:0]     ram_waddr;
  logic [idw_pkg::CNT_W-1:0]      ram_wdata;
  logic                           ram_re;
  logic [idw_pkg::CONN_W-1:0]     ram_raddr;
  logic [idw_pkg::CNT_W-1:0]      ram_rdata;

  // Membership bitmaps, one per ring slot. The sequencer reads the newest slot
  // for activity and the oldest slot while a tick retires it.
  idw_buckets u_buckets (
    .clk     (clk),
    .rst     (rst),
    .cmd     (bcmd),
    .rd_word (bkt_word)
  );

  // Per-connection reference counts. Entries never written since the last
  // clear are masked to zero by valid bits kept in the sequencer.
  idw_ram #(
    .WIDTH (idw_pkg::CNT_W),
    .DEPTH (idw_pkg::MAX_CONN)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer: accepts one beat at a time, walks the retiring bucket on a
  // tick, and holds each expiry back one step so the final one can carry last.
  idw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .evt       (evt),
    .expiry    (expiry),
    .cfg_clr   (cfg_we),
    .num_slots (num_slots),
    .bcmd      (bcmd),
    .bkt_word  (bkt_word),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule

`default_nettype wire

FILE: hdl/idw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
`default_nettype none

module idw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/idw_buckets.sv
// Bucket store of the wheel: one membership bitmap per ring slot, in flops.
// Depends on idw_pkg for the command struct and sizes.
`default_nettype none

module idw_buckets (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire idw_pkg::bkt_cmd_t             cmd,
  output logic [idw_pkg::MAX_CONN-1:0]       rd_word
);

  logic [idw_pkg::MAX_CONN-1:0] bucket_bits [idw_pkg::WHEEL_SLOTS];

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_all) begin
      for (int i = 0; i < idw_pkg::WHEEL_SLOTS; i++) begin
        bucket_bits[i] <= '0;
      end
    end else begin
      if (cmd.set_en) begin
        bucket_bits[cmd.wr_slot][cmd.id] <= 1'b1;
      end
      if (cmd.clr_en) begin
        bucket_bits[cmd.wr_slot] <= '0;
      end
    end
  end

  assign rd_word = bucket_bits[cmd.rd_slot];

endmodule

`default_nettype wire

FILE: hdl/idw_ctrl.sv
// Sequencer of the wheel: activity updates, the tick scan with the shared
// count unit, the pending expiry and the output register.
// Depends on idw_pkg, idw_in_if and idw_out_if.
`default_nettype none

module idw_ctrl (
  input  wire logic                              clk,
  input  wire logic                              rst,
  idw_in_if.sink                                 evt,
  idw_out_if.source                              expiry,
  input  wire logic                              cfg_clr,
  input  wire logic [idw_pkg::NUM_W-1:0]         num_slots,
  output idw_pkg::bkt_cmd_t                      bcmd,
  input  wire logic [idw_pkg::MAX_CONN-1:0]      bkt_word,
  output logic                                   ram_we,
  output logic      [idw_pkg::CONN_W-1:0]        ram_waddr,
  output logic      [idw_pkg::CNT_W-1:0]         ram_wdata,
  output logic                                   ram_re,
  output logic      [idw_pkg::CONN_W-1:0]        ram_raddr,
  input  wire logic [idw_pkg::CNT_W-1:0]         ram_rdata
);

  idw_pkg::state_t state, state_next;

  logic [idw_pkg::SLOT_W-1:0]   oldest, oldest_next;
  logic [idw_pkg::CONN_W-1:0]   op_id, op_id_next;
  logic                         op_ok, op_ok_next;
  logic [idw_pkg::CONN_W-1:0]   scan, scan_next;
  logic                         pend_valid, pend_valid_next;
  logic [idw_pkg::CONN_W-1:0]   pend_id, pend_id_next;
  logic                         out_valid, out_valid_next;
  logic [idw_pkg::CONN_W-1:0]   out_id, out_id_next;
  logic                         out_last, out_last_next;
  logic [idw_pkg::MAX_CONN-1:0] cnt_vld, cnt_vld_next;
  logic                         rd_vld, rd_vld_next;

  logic [idw_pkg::SLOT_W-1:0]   newest;
  logic [idw_pkg::SLOT_W-1:0]   oldest_adv;
  logic                         slot_free;
  logic [idw_pkg::CNT_W-1:0]    cnt_cur;
  logic                         cnt_dec;
  logic [idw_pkg::CNT_W-1:0]    cnt_sum;
  logic [idw_pkg::CNT_W-1:0]    cnt_new;

  assign newest     = (oldest == '0) ? idw_pkg::SLOT_W'(num_slots - idw_pkg::NUM_W'(1))
                                     : oldest - idw_pkg::SLOT_W'(1);
  assign oldest_adv = (({1'b0, oldest} + idw_pkg::NUM_W'(1)) == num_slots)
                      ? '0 : oldest + idw_pkg::SLOT_W'(1);
  assign slot_free  = !out_valid || expiry.ready;

  // The one count unit: plus one on activity, minus one while retiring a bucket.
  assign cnt_cur = rd_vld ? ram_rdata : '0;
  assign cnt_dec = (state != idw_pkg::S_ACT);
  assign cnt_sum = cnt_cur + (cnt_dec ? {idw_pkg::CNT_W{1'b1}} : idw_pkg::CNT_W'(1));
  assign cnt_new = (cnt_dec && cnt_cur == '0) ? '0 : cnt_sum;

  assign evt.ready           = (state == idw_pkg::S_IDLE);
  assign expiry.valid        = out_valid;
  assign expiry.expired_conn = idw_pkg::ID_W'(out_id);
  assign expiry.last         = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= idw_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest     <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      cnt_vld    <= '0;
    end else begin
      oldest     <= oldest_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
      cnt_vld    <= cnt_vld_next;
    end
    op_id    <= op_id_next;
    op_ok    <= op_ok_next;
    scan     <= scan_next;
    pend_id  <= pend_id_next;
    out_id   <= out_id_next;
    out_last <= out_last_next;
    rd_vld   <= rd_vld_next;
  end

  always_comb begin
    state_next      = state;
    oldest_next     = oldest;
    op_id_next      = op_id;
    op_ok_next      = op_ok;
    scan_next       = scan;
    pend_valid_next = pend_valid;
    pend_id_next    = pend_id;
    out_valid_next  = out_valid && !expiry.ready;
    out_id_next     = out_id;
    out_last_next   = out_last;
    cnt_vld_next    = cnt_vld;
    rd_vld_next     = rd_vld;

    bcmd         = '0;
    bcmd.rd_slot = oldest;
    ram_we       = 1'b0;
    ram_waddr    = scan;
    ram_wdata    = cnt_new;
    ram_re       = 1'b0;
    ram_raddr    = scan;

    unique case (state)
      idw_pkg::S_IDLE: begin
        if (evt.valid) begin
          if (evt.opcode == idw_pkg::OP_ACTIVITY) begin
            op_id_next  = idw_pkg::CONN_W'(evt.conn_id);
            op_ok_next  = 32'(evt.conn_id) < 32'(idw_pkg::MAX_CONN);
            ram_re      = 1'b1;
            ram_raddr   = idw_pkg::CONN_W'(evt.conn_id);
            rd_vld_next = cnt_vld[ram_raddr];
            state_next  = idw_pkg::S_ACT;
          end else begin
            scan_next       = '0;
            pend_valid_next = 1'b0;
            state_next      = idw_pkg::S_SCAN;
          end
        end
      end
      idw_pkg::S_ACT: begin
        bcmd.rd_slot = newest;
        if (op_ok && !bkt_word[op_id]) begin
          bcmd.set_en           = 1'b1;
          bcmd.wr_slot          = newest;
          bcmd.id               = op_id;
          ram_we                = 1'b1;
          ram_waddr             = op_id;
          cnt_vld_next[op_id]   = 1'b1;
        end
        state_next = idw_pkg::S_IDLE;
      end
      idw_pkg::S_SCAN: begin
        if (bkt_word[scan]) begin
          ram_re      = 1'b1;
          rd_vld_next = cnt_vld[scan];
          state_next  = idw_pkg::S_UPD;
        end else if (scan == idw_pkg::LAST_CONN) begin
          state_next = idw_pkg::S_END;
        end else begin
          scan_next = scan + idw_pkg::CONN_W'(1);
        end
      end
      idw_pkg::S_UPD: begin
        ram_we             = 1'b1;
        cnt_vld_next[scan] = 1'b1;
        if (cnt_new == '0 && pend_valid) begin
          state_next = idw_pkg::S_PUSH;
        end else begin
          if (cnt_new == '0) begin
            pend_valid_next = 1'b1;
            pend_id_next    = scan;
          end
          if (scan == idw_pkg::LAST_CONN) begin
            state_next = idw_pkg::S_END;
          end else begin
            scan_next  = scan + idw_pkg::CONN_W'(1);
            state_next = idw_pkg::S_SCAN;
          end
        end
      end
      idw_pkg::S_PUSH: begin
        // The earlier expiry is now known not to be the last of this tick.
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_id_next    = pend_id;
          out_last_next  = 1'b0;
          pend_id_next   = scan;
          if (scan == idw_pkg::LAST_CONN) begin
            state_next = idw_pkg::S_END;
          end else begin
            scan_next  = scan + idw_pkg::CONN_W'(1);
            state_next = idw_pkg::S_SCAN;
          end
        end
      end
      idw_pkg::S_END: begin
        if (!pend_valid || slot_free) begin
          if (pend_valid) begin
            out_valid_next = 1'b1;
            out_id_next    = pend_id;
            out_last_next  = 1'b1;
          end
          pend_valid_next = 1'b0;
          bcmd.clr_en     = 1'b1;
          bcmd.wr_slot    = oldest;
          oldest_next     = oldest_adv;
          state_next      = idw_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = idw_pkg::S_IDLE;
      end
    endcase

    if (cfg_clr) begin
      bcmd.clr_all = 1'b1;
      cnt_vld_next = '0;
      oldest_next  = '0;
    end
  end

  // Expiries of one tick leave in ascending order.
  a_ascending: assert property (@(posedge clk) disable iff (rst)
    (state == idw_pkg::S_PUSH && slot_free) |=> (pend_id > out_id))
    else $error("expiry order broken");

  // Closing a tick with a pending expiry sends it marked last and drops it.
  a_last_flush: assert property (@(posedge clk) disable iff (rst)
    (state == idw_pkg::S_END && pend_valid && slot_free)
    |=> (out_valid && out_last && !pend_valid))
    else $error("final expiry not flushed as last");

  // Activity never produces an output beat.
  a_act_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == idw_pkg::S_ACT && !out_valid) |=> !out_valid)
    else $error("activity produced an expiry");

  // The ring pointer stays inside the slots in use.
  a_oldest_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, oldest} < num_slots))
    else $error("oldest slot outside ring");

endmodule

`default_nettype wire
